// File: hw/rtl/lifo_stack_with_peek_unit_macros.svh
// ----------------------------------------------------------------------------
// lifo_stack_with_peek_unit_macros
// Assertion macros used by the LIFO stack controller RTL. Every property is clocked
// on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_PEEK_UNIT_MACROS_SVH
`define LIFO_STACK_WITH_PEEK_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define LSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define LSP_ASSERT_IMP(lbl, ante, cons, msg)
`define LSP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg
// Types, operation and status codes shared by the LIFO stack modules.
// ----------------------------------------------------------------------------
package lsp_pkg;

    // default number of entries
    localparam int LSP_DEPTH = 64;

    localparam int WORD_W = 32;
    localparam int OP_W   = 2;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [OP_W-1:0]          t_op;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [STAT_W-1:0]        t_status;

    // operation codes
    localparam t_op OP_PUSH = 2'd0;
    localparam t_op OP_POP  = 2'd1;
    localparam t_op OP_PEEK = 2'd2;

    // status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;
    localparam t_status ST_BEYOND    = 2'd3;

    // word returned when nothing can be read
    localparam t_word NONE_WORD = -32'sd1;

    // controller state
    typedef enum logic {
        S_IDLE,
        S_PEEK
    } t_state;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_dn;     // push: every entry moves one cell deeper
        logic shift_up;     // pop: every entry moves one cell toward the top
        logic load_probe;   // copy stack contents into the probe chain
        logic shift_probe;  // probe chain moves one cell toward the top
    } t_cell_ctrl;

endpackage

// File: hw/rtl/lsp_req_if.sv
// ----------------------------------------------------------------------------
// lsp_req_if
// Request channel: one stack operation per item.
// ----------------------------------------------------------------------------
interface lsp_req_if import lsp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_op   op;
    t_word push_value;
    t_pos  position;

    modport source (output valid, output op, output push_value, output position,
                    input ready);
    modport sink   (input valid, input op, input push_value, input position,
                    output ready);
endinterface

// File: hw/rtl/lsp_rsp_if.sv
// ----------------------------------------------------------------------------
// lsp_rsp_if
// Response channel: one result item per request item.
// ----------------------------------------------------------------------------
interface lsp_rsp_if import lsp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_word   read_value;
    t_status status;
    logic    is_empty;
    logic    is_full;

    modport source (output valid, output read_value, output status,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input read_value, input status,
                    input is_empty, input is_full, output ready);
endinterface

// File: hw/rtl/lifo_stack_with_peek_unit.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_peek_unit
// Bounded LIFO stack of signed 32-bit words built as a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one operation per item: push of push_value, pop of the top
//   entry, or peek at position (0 and 1 both mean the top). o_rsp returns one
//   item per request with read_value, status and the empty/full flags as they
//   stand after the operation.
//   Cell 0 holds the top entry. A push shifts every cell one place deeper, a
//   pop shifts every cell one place up; for both the
//   result is registered and shows on o_rsp the cycle after acceptance.
//   A peek at depth d copies the stack into the probe chain and walks it one
//   cell per cycle toward the top; its result is registered once the probe
//   reaches the top, and no new item is taken meanwhile. A peek beyond the
//   contents skips the walk and is answered like a push or pop.
//   Throughput is one item per cycle for push, pop and refused operations
//   while o_rsp does not stall; a walking peek blocks new items until done.
//   A stalled o_rsp holds its item; a new item is taken only in the cycle
//   the waiting one leaves. Reset (i_rst_n low, synchronous) empties the
//   stack; entry contents are not cleared.
// ----------------------------------------------------------------------------
module lifo_stack_with_peek_unit import lsp_pkg::*; #(
    parameter int DEPTH = LSP_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsp_req_if.sink   i_req,
    lsp_rsp_if.source o_rsp
);

    t_cell_ctrl w_cell_ctrl;
    t_word      w_data  [DEPTH];
    t_word      w_probe [DEPTH];

    // controller
    lsp_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_req.valid),
        .o_ready      (i_req.ready),
        .i_op         (i_req.op),
        .i_position   (i_req.position),
        .i_top_data   (w_data[0]),
        .i_top_probe  (w_probe[0]),
        .o_cell_ctrl  (w_cell_ctrl),
        .o_valid      (o_rsp.valid),
        .i_ready      (o_rsp.ready),
        .o_read_value (o_rsp.read_value),
        .o_status     (o_rsp.status),
        .o_is_empty   (o_rsp.is_empty),
        .o_is_full    (o_rsp.is_full)
    );

    // row of cells, index 0 at the top
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_word w_above;
        t_word w_below;
        t_word w_pbelow;

        if (gi == 0) begin : g_top
            assign w_above = i_req.push_value;
        end else begin : g_inner_top
            assign w_above = w_data[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_bottom
            assign w_below  = '0;
            assign w_pbelow = '0;
        end else begin : g_inner_bottom
            assign w_below  = w_data[gi+1];
            assign w_pbelow = w_probe[gi+1];
        end

        lsp_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_cell_ctrl),
            .i_word_above  (w_above),
            .i_word_below  (w_below),
            .i_probe_below (w_pbelow),
            .o_data        (w_data[gi]),
            .o_probe       (w_probe[gi])
        );
    end

endmodule

// File: hw/rtl/lsp_cell.sv
// ----------------------------------------------------------------------------
// lsp_cell
// One stack slot plus one probe slot. Stack data moves to the neighbor on
// push or pop; the probe copy walks toward the top during a peek.
// ----------------------------------------------------------------------------
module lsp_cell import lsp_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_word      i_word_above,   // entry of the cell nearer the top
    input  t_word      i_word_below,   // entry of the cell deeper down
    input  t_word      i_probe_below,  // probe of the cell deeper down
    output t_word      o_data,
    output t_word      o_probe
);

    t_word r_data;
    t_word r_probe;

    // stack slot
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift_dn) begin
            r_data <= i_word_above;
        end else if (i_ctrl.shift_up) begin
            r_data <= i_word_below;
        end
    end

    // probe slot
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_probe) begin
            r_probe <= r_data;
        end else if (i_ctrl.shift_probe) begin
            r_probe <= i_probe_below;
        end
    end

    assign o_data  = r_data;
    assign o_probe = r_probe;

endmodule

// File: hw/rtl/lsp_ctrl.sv
// ----------------------------------------------------------------------------
// lsp_ctrl
// Entry count, peek sequencer and result register of the LIFO stack.
// ----------------------------------------------------------------------------
`include "lifo_stack_with_peek_unit_macros.svh"

module lsp_ctrl import lsp_pkg::*; #(
    parameter int DEPTH = LSP_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request side
    input  logic       i_valid,
    output logic       o_ready,
    input  t_op        i_op,
    input  t_pos       i_position,
    // top cell
    input  t_word      i_top_data,
    input  t_word      i_top_probe,
    output t_cell_ctrl o_cell_ctrl,
    // response side
    output logic       o_valid,
    input  logic       i_ready,
    output t_word      o_read_value,
    output t_status    o_status,
    output logic       o_is_empty,
    output logic       o_is_full
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    t_pos          r_steps, n_steps;

    logic          r_out_valid, n_out_valid;
    t_word         r_out_value, n_out_value;
    t_status       r_out_status, n_out_status;
    logic          r_out_empty, n_out_empty;
    logic          r_out_full, n_out_full;

    logic          w_accept;
    logic          w_out_free;
    logic          w_beyond;
    t_pos          w_depth;
    logic          w_res_load;
    t_word         w_res_value;
    t_status       w_res_status;

    // handshake
    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_valid && o_ready;

    // peek depth, position 0 also means the top
    assign w_depth  = (i_position == '0) ? t_pos'(1) : i_position;
    assign w_beyond = LW'(w_depth) > LW'(r_count);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_op == OP_PEEK && !w_beyond) begin
                    n_state = S_PEEK;
                end
            end
            S_PEEK: begin
                if (r_steps == '0 && w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // cell commands, count and result
    always_comb begin
        o_cell_ctrl  = '0;
        n_count      = r_count;
        n_steps      = r_steps;
        w_res_load   = 1'b0;
        w_res_value  = '0;
        w_res_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_res_load = 1'b1;
                    case (i_op)
                        OP_PUSH: begin
                            if (r_count == FULL_CNT) begin
                                w_res_status = ST_OVERFLOW;
                            end else begin
                                o_cell_ctrl.shift_dn = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                w_res_value  = NONE_WORD;
                                w_res_status = ST_UNDERFLOW;
                            end else begin
                                w_res_value = i_top_data;
                                o_cell_ctrl.shift_up = 1'b1;
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_PEEK: begin
                            if (w_beyond) begin
                                w_res_value  = NONE_WORD;
                                w_res_status = ST_BEYOND;
                            end else begin
                                // result comes once the probe reaches the top
                                w_res_load = 1'b0;
                                o_cell_ctrl.load_probe = 1'b1;
                                n_steps = w_depth - t_pos'(1);
                            end
                        end
                        default: ;  // unused code: no change, zero result
                    endcase
                end
            end
            S_PEEK: begin
                if (r_steps == '0) begin
                    if (w_out_free) begin
                        w_res_load  = 1'b1;
                        w_res_value = i_top_probe;
                    end
                end else begin
                    o_cell_ctrl.shift_probe = 1'b1;
                    n_steps = r_steps - t_pos'(1);
                end
            end
            default: ;
        endcase
    end

    // result register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_empty  = r_out_empty;
        n_out_full   = r_out_full;
        if (w_res_load) begin
            n_out_valid  = 1'b1;
            n_out_value  = w_res_value;
            n_out_status = w_res_status;
            n_out_empty  = (n_count == '0);
            n_out_full   = (n_count == FULL_CNT);
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_steps      <= n_steps;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_empty  <= n_out_empty;
        r_out_full   <= n_out_full;
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_out_value;
    assign o_status     = r_out_status;
    assign o_is_empty   = r_out_empty;
    assign o_is_full    = r_out_full;

    // checks
    `LSP_ASSERT_NXT(a_push_count, w_accept && i_op == OP_PUSH && r_count != FULL_CNT, r_count == $past(r_count) + CW'(1), "push did not grow the count")
    `LSP_ASSERT_NXT(a_peek_hold, r_state == S_PEEK, r_count == $past(r_count), "count changed during a peek")
    `LSP_ASSERT_IMP(a_under_empty, r_out_valid && r_out_status == ST_UNDERFLOW, r_out_empty, "underflow reported on a non-empty stack")
    `LSP_ASSERT_IMP(a_over_full, r_out_valid && r_out_status == ST_OVERFLOW, r_out_full, "overflow reported on a non-full stack")

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lifo_stack_with_peek_unit. A driver replays stack
// operations from a queue, and a monitor predicts each result at acceptance
// and checks every returned item against it. A short directed run covers
// empty and out-of-range cases. Random runs mostly fill, drain and mix
// the stack, under several idle and stall profiles on both channels.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsp_pkg::*;

    localparam int   STACK_DEPTH    = LSP_DEPTH;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   END_SETTLE     = STACK_DEPTH + 20;
    // a random run may overshoot its budget by less than its last group of items
    localparam int   PHASE_ITEMS    = 189;
    // op code that the block must ignore
    localparam t_op  OP_UNUSED      = 2'd3;
    localparam t_pos POS_MAX        = '1;

    typedef struct {
        t_op   op;
        t_word push_value;
        t_pos  position;
    } stack_op_t;

    typedef struct {
        t_word   read_value;
        t_status status;
        logic    is_empty;
        logic    is_full;
    } stack_result_t;

    logic clk = 1'b0;
    logic rst_n;

    lsp_req_if req_ch ();
    lsp_rsp_if rsp_ch ();

    lifo_stack_with_peek_unit #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // operations waiting to be driven, results waiting to be returned
    stack_op_t     pending_ops[$];
    stack_result_t expected_results[$];

    // predicted stack contents, entry 0 at the bottom
    t_word         held_words[STACK_DEPTH];
    int            held_count = 0;

    // occupancy seen by the generator, used only to shape stimulus
    int            stim_fill = 0;

    int            items_loaded = 0;
    int            results_seen = 0;
    int            error_count  = 0;
    int            idle_cycles  = 0;
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;
    logic          req_taken = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t result %0d: %s", $time, results_seen, what);
        error_count++;
    endtask

    // next state and result of the stack for one accepted item
    function automatic stack_result_t predict_stack_op(input stack_op_t item);
        stack_result_t res;
        int            depth;
        res.read_value = '0;
        res.status     = ST_OK;
        case (item.op)
            OP_PUSH: begin
                if (held_count >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    held_words[held_count] = item.push_value;
                    held_count++;
                end
            end
            OP_POP: begin
                if (held_count == 0) begin
                    res.read_value = NONE_WORD;
                    res.status     = ST_UNDERFLOW;
                end else begin
                    held_count--;
                    res.read_value = held_words[held_count];
                end
            end
            OP_PEEK: begin
                depth = (item.position == 0) ? 1 : int'(item.position);
                if (depth > held_count) begin
                    res.read_value = NONE_WORD;
                    res.status     = ST_BEYOND;
                end else begin
                    res.read_value = held_words[held_count - depth];
                end
            end
            default: ;
        endcase
        res.is_empty = (held_count == 0);
        res.is_full  = (held_count == STACK_DEPTH);
        return res;
    endfunction

    // driver: new item or idle at the falling edge, random sink stalls
    always @(negedge clk) begin : drive_req
        stack_op_t nxt;
        logic      launch;
        if (!req_ch.valid || req_taken) begin
            launch = 1'b0;
            if (pending_ops.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt    = pending_ops.pop_front();
                launch = 1'b1;
            end
            req_ch.valid <= launch;
            if (launch) begin
                req_ch.op         <= nxt.op;
                req_ch.push_value <= nxt.push_value;
                req_ch.position   <= nxt.position;
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // monitor: predict on request acceptance, check on result acceptance
    always @(posedge clk) begin : watch_channels
        stack_op_t     got_op;
        stack_result_t want;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                got_op.op         = req_ch.op;
                got_op.push_value = req_ch.push_value;
                got_op.position   = req_ch.position;
                expected_results.push_back(predict_stack_op(got_op));
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_ch.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value got %h expected %h",
                                                  rsp_ch.read_value, want.read_value));
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  rsp_ch.status, want.status));
                    if (rsp_ch.is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty got %b expected %b",
                                                  rsp_ch.is_empty, want.is_empty));
                    if (rsp_ch.is_full !== want.is_full)
                        report_mismatch($sformatf("is_full got %b expected %b",
                                                  rsp_ch.is_full, want.is_full));
                end
            end
        end
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
    end

    // watchdog on cycles with no traffic on either channel
    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic queue_item(input t_op op, input t_word value, input t_pos pos);
        stack_op_t item;
        item.op         = op;
        item.push_value = value;
        item.position   = pos;
        pending_ops.push_back(item);
        items_loaded++;
        if (op == OP_PUSH && stim_fill < STACK_DEPTH)
            stim_fill++;
        else if (op == OP_POP && stim_fill > 0)
            stim_fill--;
    endtask

    function automatic t_word random_word();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return NONE_WORD;
            3:       return '0;
            default: return t_word'($urandom);
        endcase
    endfunction

    // mostly shallow peeks, since each level of depth lengthens the probe walk
    function automatic t_pos peek_pos();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return t_pos'($urandom_range((stim_fill < 4) ? stim_fill : 4));
        else if (pick < 85)
            return t_pos'($urandom_range(stim_fill));
        return t_pos'($urandom_range(int'(POS_MAX)));
    endfunction

    task automatic add_random_items(input int n);
        int  made;
        int  pick;
        int  burst;
        t_op op;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                // fill to the top, knock on the full stack, look deep
                while (stim_fill < STACK_DEPTH) begin
                    queue_item(OP_PUSH, random_word(), t_pos'($urandom));
                    made++;
                end
                repeat ($urandom_range(3, 1)) begin
                    queue_item(OP_PUSH, random_word(), t_pos'($urandom));
                    made++;
                end
                queue_item(OP_PEEK, random_word(),
                           t_pos'($urandom_range(STACK_DEPTH + 2, STACK_DEPTH - 2)));
                made++;
            end else if (pick < 27) begin
                // drain to empty, then pop and peek on nothing
                while (stim_fill > 0) begin
                    queue_item(OP_POP, random_word(), t_pos'($urandom));
                    made++;
                end
                repeat ($urandom_range(2, 1)) begin
                    queue_item(OP_POP, random_word(), t_pos'($urandom));
                    made++;
                end
                queue_item(OP_PEEK, random_word(), peek_pos());
                made++;
            end else begin
                burst = $urandom_range(40, 8);
                repeat (burst) begin
                    pick = $urandom_range(99);
                    if (pick < 36)      op = OP_PUSH;
                    else if (pick < 66) op = OP_POP;
                    else if (pick < 95) op = OP_PEEK;
                    else                op = OP_UNUSED;
                    queue_item(op, random_word(),
                               (op == OP_PEEK) ? peek_pos() : t_pos'($urandom));
                    made++;
                end
            end
        end
    endtask

    task automatic wait_for_results();
        while (results_seen < items_loaded)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial begin : stimulus
        req_ch.valid      = 1'b0;
        req_ch.op         = OP_PUSH;
        req_ch.push_value = '0;
        req_ch.position   = '0;
        rsp_ch.ready      = 1'b0;
        rst_n             = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty stack, word extremes, peek depths, unused op
        queue_item(OP_POP, '0, '0);
        queue_item(OP_PEEK, '0, '0);
        queue_item(OP_PEEK, '0, 7'd1);
        queue_item(OP_UNUSED, 32'sh1234_5678, POS_MAX);
        queue_item(OP_PUSH, 32'sh7FFF_FFFF, '0);
        queue_item(OP_PUSH, 32'sh8000_0000, POS_MAX);
        queue_item(OP_PUSH, NONE_WORD, '0);
        queue_item(OP_PUSH, '0, '0);
        queue_item(OP_PUSH, 32'sh5555_AAAA, '0);
        queue_item(OP_PEEK, '0, '0);
        queue_item(OP_PEEK, '0, 7'd1);
        queue_item(OP_PEEK, NONE_WORD, 7'd5);
        queue_item(OP_PEEK, '0, 7'd6);
        queue_item(OP_PEEK, '0, 7'd64);
        queue_item(OP_PEEK, '0, POS_MAX);
        queue_item(OP_UNUSED, NONE_WORD, 7'd3);
        repeat (6) queue_item(OP_POP, NONE_WORD, POS_MAX);
        queue_item(OP_PUSH, 32'sh0000_0001, '0);
        queue_item(OP_PEEK, '0, 7'd2);
        wait_for_results();

        // random runs, each ending with a full drain of results
        src_idle_pct = 0;  sink_stall_pct = 0;
        add_random_items(PHASE_ITEMS);
        wait_for_results();
        src_idle_pct = 72; sink_stall_pct = 0;
        add_random_items(PHASE_ITEMS);
        wait_for_results();
        src_idle_pct = 0;  sink_stall_pct = 72;
        add_random_items(PHASE_ITEMS);
        wait_for_results();
        src_idle_pct = 32; sink_stall_pct = 32;
        add_random_items(PHASE_ITEMS);
        wait_for_results();

        // let any stray result show up
        repeat (END_SETTLE) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_req_if.sv
hw/rtl/lsp_rsp_if.sv
hw/rtl/lsp_cell.sv
hw/rtl/lsp_ctrl.sv
hw/rtl/lifo_stack_with_peek_unit.sv
dv/tb.sv
